// ===== src/icv_pkg.sv =====
// Shared types and constants for the 2-D image convolution block.
// No dependencies; imported by every module of the block except icv_line_mem.
`timescale 1ns / 1ps
`default_nettype none

package icv_pkg;

    localparam int FRAC_BITS   = 10;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_LOAD  = 1'b1;

    typedef struct packed {
        logic               command;
        logic [7:0]         pixel;
        logic [5:0]         coeff_index;
        logic signed [15:0] coeff_value;
    } in_t;

    typedef struct packed {
        logic [7:0]  out_pixel;
        logic [10:0] out_row;
        logic [10:0] out_col;
        logic        last;
    } out_t;

    // Per-pixel bookkeeping carried down the pipeline
    typedef struct packed {
        logic        prod;
        logic [10:0] row;
        logic [10:0] col;
        logic        last;
    } meta_t;

endpackage

`default_nettype wire

// ===== src/icv_line_mem.sv =====
// Line store: one word per image column holding the buffered rows above.
// Simple dual-port synchronous RAM, registered read; uses no package items.
`timescale 1ns / 1ps
`default_nettype none

module icv_line_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 48
) (
    input  wire logic          aclk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/icv_mac.sv =====
// Window multiply-accumulate: product lanes, row sums, total and clip.
// Depends on icv_pkg (meta_t, FRAC_BITS).
`timescale 1ns / 1ps
`default_nettype none

module icv_mac #(
    parameter int MW = 7,
    parameter int CW = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    input  wire icv_pkg::meta_t       in_meta,
    input  wire logic [7:0]           win [MW][MW],
    input  wire logic signed [CW-1:0] coef [MW][MW],
    output logic                      out_valid,
    output icv_pkg::meta_t            out_meta,
    output logic [7:0]                out_pixel
);
    import icv_pkg::*;

    localparam int PW  = CW + 9;
    localparam int GW  = $clog2(MW) + 1;
    localparam int RSW = PW + GW;
    localparam int SW  = RSW + GW;

    logic signed [PW-1:0]  prod_reg [MW][MW];
    logic signed [RSW-1:0] row_reg [MW];
    logic signed [RSW-1:0] row_next [MW];
    logic signed [SW-1:0]  sum_reg;
    logic signed [SW-1:0]  sum_next;
    logic [2:0]            valid_reg;
    meta_t                 meta_reg [3];
    logic [SW-1:0]         quot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        meta_reg[0] <= in_meta;
        meta_reg[1] <= meta_reg[0];
        meta_reg[2] <= meta_reg[1];
        // Force zero taps to zero so unwritten line store bytes never reach the sum
        for (int i = 0; i < MW; i++) begin
            for (int j = 0; j < MW; j++) begin
                if (coef[i][j] == '0) begin
                    prod_reg[i][j] <= '0;
                end else begin
                    prod_reg[i][j] <= PW'($signed({1'b0, win[i][j]}) * coef[i][j]);
                end
            end
        end
        row_reg <= row_next;
        sum_reg <= sum_next;
    end

    always_comb begin
        for (int i = 0; i < MW; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < MW; j++) begin
                row_next[i] = row_next[i] + RSW'(prod_reg[i][j]);
            end
        end
    end

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < MW; i++) begin
            sum_next = sum_next + SW'(row_reg[i]);
        end
    end

    // Clip: negative gives zero, otherwise drop fraction and saturate
    always_comb begin
        quot = $unsigned(sum_reg) >> FRAC_BITS;
        if (sum_reg < 0) begin
            out_pixel = 8'd0;
        end else if (quot > SW'(255)) begin
            out_pixel = 8'd255;
        end else begin
            out_pixel = quot[7:0];
        end
    end

    assign out_valid = valid_reg[2];
    assign out_meta  = meta_reg[2];

endmodule

`default_nettype wire

// ===== src/icv_out_fifo.sv =====
// Result queue between the pipeline and the output channel.
// Depends on icv_pkg (out_t).
`timescale 1ns / 1ps
`default_nettype none

module icv_out_fifo #(
    parameter int DEPTH = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire icv_pkg::out_t push_data,
    input  wire logic          pop,
    output logic               valid,
    output icv_pkg::out_t      data
);
    import icv_pkg::*;

    localparam int PTRW = $clog2(DEPTH);

    out_t            buf_mem [DEPTH];
    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [PTRW:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PTRW+1)'(push) - (PTRW+1)'(pop);
        end
    end

    assign valid = (count_reg != '0);
    assign data  = buf_mem[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== src/image_convolution_2d.sv =====
// Top level of the streaming 2-D image convolution block.
// Depends on icv_pkg, icv_line_mem, icv_mac and icv_out_fifo.
`timescale 1ns / 1ps
`default_nettype none

// Pixels enter in raster order, one beat per clock, interleaved with coefficient
// loads. A line store RAM keeps one word per column with the previous
// MAX_WINDOW-1 rows; each pixel reads its column word, shifts itself in and
// writes it back, with forwarding when a one-pixel-wide image hits the same
// word on back-to-back beats. The column feeds a window register array; a
// bank of product lanes and a registered sum tree produce the result of each
// pixel beat. Sustained rate is one beat per clock. Results
// drain through a 16-entry queue; s_ready falls only while queued plus
// in-flight pixels fill that queue. Border pixels produce no result beat.
// Any register write restarts the frame at row 0, column 0; coefficients
// stay. The line store needs no clearing pass after reset.
module image_convolution_2d #(
    parameter int MAX_WIDTH   = 2048,
    parameter int MAX_HEIGHT  = 2048,
    parameter int MAX_WINDOW  = 7,
    parameter int COEFF_WIDTH = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire icv_pkg::in_t                    s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output icv_pkg::out_t                        m_data,
    input  wire logic                            cfg_we,
    input  wire logic [icv_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [icv_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import icv_pkg::*;

    localparam int MW     = MAX_WINDOW;
    localparam int CAW    = $clog2(MAX_WIDTH);
    localparam int RAW    = $clog2(MAX_HEIGHT);
    localparam int DIMW   = 14;
    localparam int LINES  = MW - 1;
    localparam int MEMW   = ((LINES > 0) ? LINES : 1) * 8;
    localparam int NCOEF  = MW * MW;
    localparam int CIW    = (NCOEF > 1) ? $clog2(NCOEF) : 1;
    localparam int QDEPTH = 16;
    localparam int PENDW  = $clog2(QDEPTH) + 1;

    localparam logic signed [32:0] C_HI = (33'sd1 <<< (COEFF_WIDTH - 1)) - 33'sd1;
    localparam logic signed [32:0] C_LO = -(33'sd1 <<< (COEFF_WIDTH - 1));

    // Configuration
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [2:0]            wsize_reg;

    // Position of the next pixel
    logic [CAW-1:0] col_reg;
    logic [RAW-1:0] row_reg;

    logic signed [COEFF_WIDTH-1:0] coeff_reg [NCOEF];
    logic [7:0]                    win_reg [MW][MW];
    logic signed [COEFF_WIDTH-1:0] csel_reg [MW][MW];
    logic signed [COEFF_WIDTH-1:0] csel [MW][MW];

    // Stage 1: line store word returns
    logic           s1_valid_reg;
    logic [7:0]     s1_px_reg;
    logic [CAW-1:0] s1_addr_reg;
    meta_t          s1_meta_reg;
    logic           s1_fwd_reg;
    logic [MEMW-1:0] fwd_word_reg;

    // Stage 2: window and coefficients ready for the lanes
    logic  s2_valid_reg;
    meta_t s2_meta_reg;

    logic [PENDW-1:0] pend_reg;

    logic [DIMW-1:0] w_eff, h_eff;
    logic [3:0]      ws_eff;
    logic [2:0]      half;
    logic [3:0]      span;
    logic            accept, pix_accept, load_accept;
    meta_t           new_meta;
    logic [DIMW-1:0] row_ext, col_ext;
    logic            end_of_row, end_of_frame;

    logic [MEMW-1:0] rd_word, old_word, new_word;
    logic [7:0]      column [MW];
    logic            wr_en;

    logic            mac_valid;
    meta_t           mac_meta;
    logic [7:0]      mac_pixel;
    logic            q_push, q_pop, drop;
    out_t            q_data;

    logic signed [32:0] cv_ext, cv_sat;
    logic [7:0]         cidx;

    // Effective dimensions: zero acts as one, oversize clamps to the maximum
    always_comb begin
        if (width_reg == '0) begin
            w_eff = DIMW'(1);
        end else if (DIMW'(width_reg) > DIMW'(MAX_WIDTH)) begin
            w_eff = DIMW'(MAX_WIDTH);
        end else begin
            w_eff = DIMW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = DIMW'(1);
        end else if (DIMW'(height_reg) > DIMW'(MAX_HEIGHT)) begin
            h_eff = DIMW'(MAX_HEIGHT);
        end else begin
            h_eff = DIMW'(height_reg);
        end
        if (4'(wsize_reg) > 4'(MW)) begin
            ws_eff = 4'(MW);
        end else begin
            ws_eff = 4'(wsize_reg);
        end
        half = 3'((ws_eff - 4'd1) >> 1);
        span = {half, 1'b0};
    end

    assign accept      = s_valid && s_ready;
    assign pix_accept  = accept && (s_data.command == CMD_PIXEL);
    assign load_accept = accept && (s_data.command == CMD_LOAD);
    assign s_ready     = (pend_reg < PENDW'(QDEPTH));

    assign row_ext      = DIMW'(row_reg);
    assign col_ext      = DIMW'(col_reg);
    assign end_of_row   = (col_ext + DIMW'(1) >= w_eff);
    assign end_of_frame = (row_ext + DIMW'(1) >= h_eff);

    always_comb begin
        new_meta.prod = (ws_eff != 4'd0) && (row_ext >= DIMW'(span))
                        && (col_ext >= DIMW'(span));
        new_meta.row  = 11'(row_ext - DIMW'(half));
        new_meta.col  = 11'(col_ext - DIMW'(half));
        new_meta.last = (row_ext + DIMW'(1) == h_eff) && (col_ext + DIMW'(1) == w_eff);
    end

    // Configuration writes; any listed register restarts the frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 12'd640;
            height_reg <= 12'd480;
            wsize_reg  <= 3'd3;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT
                                || cfg_index == CFG_WINDOW_SIZE)) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                CFG_WINDOW_SIZE:  wsize_reg  <= cfg_data[2:0];
                default:          ;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end else if (pix_accept) begin
            if (end_of_row) begin
                col_reg <= '0;
                row_reg <= end_of_frame ? '0 : row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // Coefficient loads, saturated to the stored width
    always_comb begin
        cv_ext = 33'(s_data.coeff_value);
        if (cv_ext > C_HI) begin
            cv_sat = C_HI;
        end else if (cv_ext < C_LO) begin
            cv_sat = C_LO;
        end else begin
            cv_sat = cv_ext;
        end
        cidx = 8'(s_data.coeff_index);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NCOEF; i++) begin
                coeff_reg[i] <= '0;
            end
        end else if (load_accept && (cidx < 8'(NCOEF))) begin
            coeff_reg[cidx[CIW-1:0]] <= COEFF_WIDTH'(cv_sat);
        end
    end

    // Line store with read-modify-write of the column word
    assign wr_en = s1_valid_reg;

    icv_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CAW),
        .DW    (MEMW)
    ) u_line_mem (
        .aclk    (aclk),
        .rd_en   (pix_accept),
        .rd_addr (col_reg),
        .rd_data (rd_word),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (new_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= pix_accept;
        end
    end

    // Capture a write that lands on the word being read in the same cycle
    always_ff @(posedge aclk) begin
        if (pix_accept) begin
            s1_px_reg    <= s_data.pixel;
            s1_addr_reg  <= col_reg;
            s1_meta_reg  <= new_meta;
            s1_fwd_reg   <= wr_en && (s1_addr_reg == col_reg);
            fwd_word_reg <= new_word;
        end
    end

    // Oldest row sits in the low byte; shift each byte down and append the new pixel on top
    always_comb begin
        old_word = s1_fwd_reg ? fwd_word_reg : rd_word;
        new_word = old_word;
        for (int k = 0; k < MW; k++) begin
            column[k] = s1_px_reg;
        end
        for (int k = 0; k < LINES; k++) begin
            column[k] = old_word[k*8 +: 8];
            if (k == LINES - 1) begin
                new_word[k*8 +: 8] = s1_px_reg;
            end else begin
                new_word[k*8 +: 8] = old_word[(k+1)*8 +: 8];
            end
        end
    end

    // Coefficient for each window position, given the active window size
    always_comb begin
        for (int i = 0; i < MW; i++) begin
            for (int j = 0; j < MW; j++) begin
                csel[i][j] = '0;
                for (int v = 1; v <= MW; v++) begin
                    if ((ws_eff == 4'(v)) && (i >= MW - 1 - 2*((v-1)/2))
                        && (j >= MW - 1 - 2*((v-1)/2))) begin
                        csel[i][j] = coeff_reg[CIW'((i - (MW - 1 - 2*((v-1)/2))) * v
                                                     + (j - (MW - 1 - 2*((v-1)/2))))];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MW; i++) begin
                for (int j = 0; j < MW; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (s1_valid_reg) begin
            for (int i = 0; i < MW; i++) begin
                for (int j = 0; j < MW - 1; j++) begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
                win_reg[i][MW-1] <= column[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s2_meta_reg <= s1_meta_reg;
        csel_reg    <= csel;
    end

    icv_mac #(
        .MW (MW),
        .CW (COEFF_WIDTH)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid_reg),
        .in_meta   (s2_meta_reg),
        .win       (win_reg),
        .coef      (csel_reg),
        .out_valid (mac_valid),
        .out_meta  (mac_meta),
        .out_pixel (mac_pixel)
    );

    // Queue interior results; drop border pixels at the pipeline exit
    assign q_push = mac_valid && mac_meta.prod;
    assign drop   = mac_valid && !mac_meta.prod;
    assign q_pop  = m_valid && m_ready;

    always_comb begin
        q_data.out_pixel = mac_pixel;
        q_data.out_row   = mac_meta.row;
        q_data.out_col   = mac_meta.col;
        q_data.last      = mac_meta.last;
    end

    icv_out_fifo #(
        .DEPTH (QDEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .valid     (m_valid),
        .data      (m_data)
    );

    // Count pixels in flight plus queued results to hold back input
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + PENDW'(pix_accept) - PENDW'(drop) - PENDW'(q_pop);
        end
    end

endmodule

`default_nettype wire

// ===== tb/icv_checker.sv =====
// Scoreboard for image_convolution_2d: mirrors the line store, window and
// coefficients, predicts each result beat and compares. Depends on icv_pkg.
`timescale 1ns / 1ps

module icv_checker
    import icv_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  in_t                    s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  out_t                   m_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     errors,
    output int                     pending
);

    localparam int WIN   = 7;
    localparam int LINES = WIN - 1;
    localparam int MAXW  = 2048;
    localparam int MAXH  = 2048;

    logic [11:0]        width_reg, height_reg;
    logic [2:0]         win_reg;
    logic signed [15:0] coeff_mem [WIN*WIN];
    logic [7:0]         line_mem  [LINES][MAXW];
    logic [7:0]         win_regs  [WIN][WIN];
    int unsigned        row_pos, col_pos;
    out_t               expected_beats [$];

    assign pending = expected_beats.size();

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    task automatic clear_model();
        width_reg  = 12'd640;
        height_reg = 12'd480;
        win_reg    = 3'd3;
        row_pos    = 0;
        col_pos    = 0;
        foreach (coeff_mem[i]) coeff_mem[i] = '0;
        foreach (win_regs[i, j]) win_regs[i][j] = '0;
        foreach (line_mem[i, j]) line_mem[i][j] = '0;
    endtask

    task automatic convolve_pixel(logic [7:0] px);
        int unsigned w, h, r, c, ws, n, base;
        logic [7:0]  column [WIN];
        longint      acc;
        out_t        beat;
        w = clamp_dim(width_reg, MAXW);
        h = clamp_dim(height_reg, MAXH);
        r = row_pos;
        c = col_pos;
        for (int k = 0; k < LINES; k++) column[k] = line_mem[(r + k) % LINES][c];
        column[WIN-1] = px;
        for (int k = 0; k < WIN; k++) begin
            for (int l = 0; l < WIN - 1; l++) win_regs[k][l] = win_regs[k][l+1];
            win_regs[k][WIN-1] = column[k];
        end
        line_mem[r % LINES][c] = px;
        ws = win_reg;
        if (ws > 0) begin
            n = (ws - 1) >> 1;
            if (r >= 2 * n && c >= 2 * n) begin
                acc  = 0;
                base = WIN - 1 - 2 * n;
                for (int k = 0; k <= 2 * n; k++)
                    for (int l = 0; l <= 2 * n; l++)
                        acc += longint'(win_regs[base+k][base+l]) * coeff_mem[k*ws+l];
                if (acc < 0) beat.out_pixel = 8'd0;
                else if ((acc >>> FRAC_BITS) > 255) beat.out_pixel = 8'd255;
                else beat.out_pixel = 8'(acc >>> FRAC_BITS);
                beat.out_row = 11'(r - n);
                beat.out_col = 11'(c - n);
                beat.last    = (r + 1 == h) && (c + 1 == w);
                expected_beats.push_back(beat);
            end
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_pos = r;
        col_pos = c;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_model();
            expected_beats.delete();
            errors <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  = cfg_data;
                    CFG_IMAGE_HEIGHT: height_reg = cfg_data;
                    CFG_WINDOW_SIZE:  win_reg    = cfg_data[2:0];
                    default: ;
                endcase
                if (cfg_index inside {CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_WINDOW_SIZE}) begin
                    row_pos = 0;
                    col_pos = 0;
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.command == CMD_LOAD) begin
                    if (s_data.coeff_index < WIN * WIN)
                        coeff_mem[s_data.coeff_index] = s_data.coeff_value;
                end else begin
                    convolve_pixel(s_data.pixel);
                end
            end
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result beat: pix=%0d row=%0d col=%0d last=%0b",
                                 m_data.out_pixel, m_data.out_row, m_data.out_col,
                                 m_data.last);
                    errors <= errors + 1;
                end else begin
                    out_t want;
                    want = expected_beats.pop_front();
                    if (m_data.out_pixel !== want.out_pixel || m_data.out_row !== want.out_row
                        || m_data.out_col !== want.out_col || m_data.last !== want.last) begin
                        if (errors < 10)
                            $display("mismatch: exp pix=%0d row=%0d col=%0d last=%0b, ",
                                     want.out_pixel, want.out_row, want.out_col, want.last,
                                     "got pix=%0d row=%0d col=%0d last=%0b",
                                     m_data.out_pixel, m_data.out_row, m_data.out_col,
                                     m_data.last);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/image_convolution_2d_tb.sv =====
// Testbench top for image_convolution_2d: drives pixel and coefficient beats,
// register writes and back-pressure. Depends on icv_pkg and icv_checker.
`timescale 1ns / 1ps

module image_convolution_2d_tb;
    import icv_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    in_t                    s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_t                   m_data;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    int                     errors, pending;
    int                     cycles = 0;
    int                     beats_sent = 0;
    int                     send_idle_pct = 16;
    int                     recv_stall_pct = 46;

    image_convolution_2d dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    icv_checker scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("image_convolution_2d_tb: FAIL");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Drive one beat; enter and leave at a falling edge. Valid holds until taken.
    task automatic send_beat(in_t item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        #1;
        while (!s_ready) begin
            @(negedge aclk);
            #1;
        end
        @(negedge aclk);
        beats_sent++;
        // switch idle profile by progress through the run
        if (beats_sent == 250) begin
            send_idle_pct  = 46;
            recv_stall_pct = 16;
        end else if (beats_sent == 500) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    endtask

    task automatic send_pixel(logic [7:0] px);
        in_t item;
        item = '0;
        item.command     = CMD_PIXEL;
        item.pixel       = px;
        item.coeff_index = 6'($urandom);
        item.coeff_value = 16'($urandom);
        send_beat(item);
    endtask

    task automatic load_coeff(logic [5:0] slot, logic [15:0] value);
        in_t item;
        item.command     = CMD_LOAD;
        item.pixel       = 8'($urandom);
        item.coeff_index = slot;
        item.coeff_value = value;
        send_beat(item);
    endtask

    // Drain everything in flight, then let border pixels clear the pipeline.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_coeff();
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'($urandom_range(2047) - 1024);
    endfunction

    initial begin
        int w, h, ws, we, he, beats;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: single-tap window, widest row, height zero (acts as one)
        write_reg(CFG_WINDOW_SIZE, 12'd1);
        write_reg(CFG_IMAGE_WIDTH, 12'd4095);
        write_reg(CFG_IMAGE_HEIGHT, 12'd0);
        load_coeff(6'd0, 16'd1024);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd128);
        load_coeff(6'd0, 16'h7fff);
        send_pixel(8'd1);
        send_pixel(8'd255);
        load_coeff(6'd0, 16'h8000);
        send_pixel(8'd10);
        load_coeff(6'd63, 16'd1024);   // out of range: drop
        load_coeff(6'd48, 16'h7fff);
        send_pixel(8'd200);
        settle();

        // Directed: 3x3 frame, one interior pixel carrying last; zero window after
        write_reg(CFG_IMAGE_WIDTH, 12'd3);
        write_reg(CFG_IMAGE_HEIGHT, 12'd3);
        write_reg(CFG_WINDOW_SIZE, 12'd3);
        load_coeff(6'd4, 16'd512);
        for (int i = 0; i < 9; i++) send_pixel(8'(i * 31));
        settle();
        write_reg(CFG_WINDOW_SIZE, 12'd0);
        for (int i = 0; i < 4; i++) send_pixel(8'($urandom));
        settle();

        // Random phases: new shape, fresh coefficients, whole and partial frames
        while (beats_sent < 750) begin
            ws = $urandom_range(7);
            case ($urandom_range(9))
                0: w = 0;
                1: w = 4095;
                default: w = $urandom_range(12, 1);
            endcase
            case ($urandom_range(9))
                0: h = 0;
                1: h = 4095;
                default: h = $urandom_range(10, 1);
            endcase
            write_reg(CFG_WINDOW_SIZE, 12'(ws));
            write_reg(CFG_IMAGE_WIDTH, 12'(w));
            write_reg(CFG_IMAGE_HEIGHT, 12'(h));
            for (int i = 0; i < ws * ws; i++) load_coeff(6'(i), pick_coeff());
            we = (w == 0) ? 1 : (w > 2048 ? 2048 : w);
            he = (h == 0) ? 1 : (h > 2048 ? 2048 : h);
            beats = we * he * $urandom_range(2, 1) + $urandom_range(5);
            if (beats > 80) beats = $urandom_range(80, 20);
            for (int i = 0; i < beats; i++) begin
                // occasional stray load in the pixel stream
                if ($urandom_range(19) == 0) load_coeff(6'($urandom), pick_coeff());
                else send_pixel(8'($urandom));
            end
            settle();
        end

        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0) begin
            $display("image_convolution_2d_tb: PASS");
        end else begin
            $display("image_convolution_2d_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/icv_pkg.sv
src/icv_line_mem.sv
src/icv_mac.sv
src/icv_out_fifo.sv
src/image_convolution_2d.sv
tb/icv_checker.sv
tb/image_convolution_2d_tb.sv
